// ----- hw/rtl/rcu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcu_pkg - ranked count table shared definitions
// Field widths, entry record, status codes, sequencer states.
// ----------------------------------------------------------------------------
package rcu_pkg;

  localparam int ITEM_W  = 31;
  localparam int ACTOR_W = 32;
  localparam int COUNT_W = 31;
  localparam int DELTA_W = 32;
  localparam int RANK_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_FULL       = 3'd2,
    ST_READ_OK    = 3'd3,
    ST_READ_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_WRITE,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ITEM_W-1:0]  item;
    logic [ACTOR_W-1:0] actor;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Ring control from the sequencer to the cell chain.
  typedef struct packed {
    logic   shift;
    entry_t head_out;
  } ring_t;

endpackage

// ----- hw/rtl/rcu_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcu_channels - request and result channel interfaces
// Valid/ready channels carrying the request and result payloads.
// ----------------------------------------------------------------------------
interface rcu_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [rcu_pkg::ITEM_W-1:0]        item_id;
  logic signed [rcu_pkg::DELTA_W-1:0] delta;
  logic [rcu_pkg::ACTOR_W-1:0]       actor_id;
  logic                              rerank;
  logic [rcu_pkg::RANK_W-1:0]        rank_index;

  modport source (
    output valid, action, item_id, delta, actor_id, rerank, rank_index,
    input  ready
  );
  modport sink (
    input  valid, action, item_id, delta, actor_id, rerank, rank_index,
    output ready
  );
endinterface

interface rcu_out_if;
  logic                         valid;
  logic                         ready;
  logic [rcu_pkg::COUNT_W-1:0]  new_count;
  logic [rcu_pkg::RANK_W-1:0]   rank_position;
  rcu_pkg::status_t             status;
  logic [rcu_pkg::ITEM_W-1:0]   read_item_id;
  logic [rcu_pkg::ACTOR_W-1:0]  read_actor_id;

  modport source (
    output valid, new_count, rank_position, status, read_item_id, read_actor_id,
    input  ready
  );
  modport sink (
    input  valid, new_count, rank_position, status, read_item_id, read_actor_id,
    output ready
  );
endinterface

// ----- hw/rtl/rcu_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcu_cell - one table entry in the rotating chain
// Holds item, actor, count; on shift loads d (neighbor, or head_out at tail).
// ----------------------------------------------------------------------------
module rcu_cell (
  input  logic            clk,
  input  logic            shift,
  input  rcu_pkg::entry_t d,
  output rcu_pkg::entry_t q
);
  import rcu_pkg::*;

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= d;
    end
  end

  assign q = entry_r;

endmodule

// ----- hw/rtl/rcu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcu_ctrl - head-of-ring sequencer
// Sees one head entry per cycle in a pass: search, write, move, read.
// ----------------------------------------------------------------------------
module rcu_ctrl #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  rcu_in_if.sink          in_ch,
  rcu_out_if.source       out_ch,
  input  rcu_pkg::entry_t head_in,
  output rcu_pkg::ring_t  ring
);
  import rcu_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int TW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = COUNT_W + 2;
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
  localparam logic [TW-1:0] FULL = TW'(TABLE_DEPTH);

  state_t               state_r, state_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic [TW-1:0]        total_r, total_nxt;
  logic [ITEM_W-1:0]    item_r, item_nxt;
  logic [ACTOR_W-1:0]   actor_r, actor_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic                 rerank_r, rerank_nxt;
  logic [RANK_W-1:0]    ridx_r, ridx_nxt;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        p_r, p_nxt;
  entry_t               ent_r, ent_nxt;
  entry_t               carry_r, carry_nxt;
  status_t              st_r, st_nxt;
  logic [RANK_W-1:0]    pos_r, pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  entry_t               out_ent_r, out_ent_nxt;
  logic [RANK_W-1:0]    out_pos_r, out_pos_nxt;
  status_t              out_st_r, out_st_nxt;

  logic                 match;
  logic                 in_use;
  logic                 last_k;
  logic                 read_hit;
  logic                 in_range;
  logic                 out_free;
  logic signed [SW-1:0] sum;
  logic [COUNT_W-1:0]   sat_count;
  logic [COUNT_W-1:0]   ins_count;

  assign match    = (head_in.item == item_r) &&
                    ((head_in.actor == actor_r) || (actor_r == '0));
  assign in_use   = TW'(k_r) < total_r;
  assign last_k   = (k_r == LAST);
  assign read_hit = (32'(k_r) == 32'(ridx_r));
  assign in_range = (32'(in_ch.rank_index) < 32'(total_r));
  assign out_free = !out_valid_r || out_ch.ready;

  assign sum = $signed({2'b00, ent_r.count}) + SW'(delta_r);

  always_comb begin
    if (sum < 0) begin
      sat_count = '0;
    end else if (sum > $signed({2'b00, COUNT_MAX})) begin
      sat_count = COUNT_MAX;
    end else begin
      sat_count = sum[COUNT_W-1:0];
    end
  end

  assign ins_count = delta_r[DELTA_W-1] ? '0 : delta_r[COUNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    total_nxt     = total_r;
    item_nxt      = item_r;
    actor_nxt     = actor_r;
    delta_nxt     = delta_r;
    rerank_nxt    = rerank_r;
    ridx_nxt      = ridx_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    ent_nxt       = ent_r;
    carry_nxt     = carry_r;
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_ent_nxt   = out_ent_r;
    out_pos_nxt   = out_pos_r;
    out_st_nxt    = out_st_r;
    ring.shift    = 1'b0;
    ring.head_out = head_in;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt   = in_ch.item_id;
          actor_nxt  = in_ch.actor_id;
          delta_nxt  = in_ch.delta;
          rerank_nxt = in_ch.rerank;
          ridx_nxt   = in_ch.rank_index;
          k_nxt      = '0;
          found_nxt  = 1'b0;
          p_nxt      = '0;
          if (in_ch.action == ACT_READ) begin
            if (in_range) begin
              state_nxt = S_READ;
            end else begin
              ent_nxt   = '0;
              pos_nxt   = in_ch.rank_index;
              st_nxt    = ST_READ_RANGE;
              state_nxt = S_DONE;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ring.shift = 1'b1;
        k_nxt      = last_k ? '0 : k_r + 1'b1;
        // later hits override: the one closest to the end wins
        if (in_use && match) begin
          found_nxt = 1'b1;
          idx_nxt   = k_r;
          ent_nxt   = head_in;
        end
        if (last_k) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (found_r) begin
          ent_nxt.count = sat_count;
          st_nxt        = ST_UPDATED;
          state_nxt     = S_WRITE;
        end else if (total_r == FULL) begin
          ent_nxt.item  = item_r;
          ent_nxt.actor = actor_r;
          ent_nxt.count = '0;
          pos_nxt       = '0;
          st_nxt        = ST_FULL;
          state_nxt     = S_DONE;
        end else begin
          idx_nxt       = IW'(total_r);
          ent_nxt.item  = item_r;
          ent_nxt.actor = actor_r;
          ent_nxt.count = ins_count;
          total_nxt     = total_r + 1'b1;
          st_nxt        = ST_INSERTED;
          state_nxt     = S_WRITE;
        end
      end
      S_WRITE: begin
        ring.shift = 1'b1;
        k_nxt      = last_k ? '0 : k_r + 1'b1;
        if (k_r == idx_r) begin
          ring.head_out = ent_r;
        end else if ((k_r < idx_r) && (head_in.count > ent_r.count)) begin
          p_nxt = k_r + 1'b1;
        end
        if (last_k) begin
          if (rerank_r && (p_r != idx_r)) begin
            state_nxt = S_SHIFT;
          end else begin
            pos_nxt   = RANK_W'(idx_r);
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        ring.shift = 1'b1;
        k_nxt      = last_k ? '0 : k_r + 1'b1;
        if (k_r == p_r) begin
          ring.head_out = ent_r;
          carry_nxt     = head_in;
        end else if ((k_r > p_r) && (k_r <= idx_r)) begin
          ring.head_out = carry_r;
          carry_nxt     = head_in;
        end
        if (last_k) begin
          pos_nxt   = RANK_W'(p_r);
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        ring.shift = 1'b1;
        k_nxt      = last_k ? '0 : k_r + 1'b1;
        if (read_hit) begin
          ent_nxt = head_in;
        end
        if (last_k) begin
          pos_nxt   = ridx_r;
          st_nxt    = ST_READ_OK;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ent_nxt   = ent_r;
          out_pos_nxt   = pos_r;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    item_r    <= item_nxt;
    actor_r   <= actor_nxt;
    delta_r   <= delta_nxt;
    rerank_r  <= rerank_nxt;
    ridx_r    <= ridx_nxt;
    found_r   <= found_nxt;
    idx_r     <= idx_nxt;
    p_r       <= p_nxt;
    ent_r     <= ent_nxt;
    carry_r   <= carry_nxt;
    st_r      <= st_nxt;
    pos_r     <= pos_nxt;
    out_ent_r <= out_ent_nxt;
    out_pos_r <= out_pos_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_count     = out_ent_r.count;
  assign out_ch.rank_position = out_pos_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.read_item_id  = out_ent_r.item;
  assign out_ch.read_actor_id = out_ent_r.actor;

endmodule

// ----- hw/rtl/ranked_count_table_update_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranked_count_table_update_top - rank-ordered count table
// Entries live in a ring of TABLE_DEPTH cells that rotates one place per
// cycle in a pass, past a head sequencer that searches, writes, moves them.
//
// Passes of the ring from request accept to result valid: an update
//   makes a search pass and a write pass, plus a move pass when it moves up;
//   table full takes the search pass only; a read takes one read pass and a
//   read out of range none. Add any wait for the result register to free up.
// One request at a time; the next is taken from the cycle after the result
// is loaded.
// Reset (rst_n, sync) empties the table; cell contents are not cleared.
// ----------------------------------------------------------------------------
module ranked_count_table_update_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  rcu_in_if.sink    in_ch,
  rcu_out_if.source out_ch
);
  import rcu_pkg::*;

  entry_t cell_q [TABLE_DEPTH];
  ring_t  ring;

  rcu_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .head_in(cell_q[0]),
    .ring   (ring)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      rcu_cell u_cell (
        .clk  (clk),
        .shift(ring.shift),
        .d    (ring.head_out),
        .q    (cell_q[i])
      );
    end else begin : g_body
      rcu_cell u_cell (
        .clk  (clk),
        .shift(ring.shift),
        .d    (cell_q[i+1]),
        .q    (cell_q[i])
      );
    end
  end

  a_ring_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ring.shift |-> !in_ch.ready)
    else $error("ring rotates while accepting requests");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken without going busy");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_FULL)) |->
      ((out_ch.new_count == '0) && (out_ch.rank_position == '0)))
    else $error("table full result carries count or position");

  a_range_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_READ_RANGE)) |->
      ((out_ch.new_count == '0) && (out_ch.read_item_id == '0) &&
       (out_ch.read_actor_id == '0)))
    else $error("out of range read returns entry data");

endmodule
